/* rtl/rnacla_pkg.sv */
// Shared types, constants and pairing rule for the RNA complement alignment row.
package rnacla_pkg;

  localparam int unsigned BASE_W  = 3;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SCORE_W = 14;
  localparam int unsigned CAND_W  = 16;
  localparam int unsigned TRACE_W = 3;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned IDX_W   = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_MATCH    = 2'd0,
    REG_MISMATCH = 2'd1,
    REG_GAP      = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic row_start;
    logic col_step;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic last_col;
  } status_t;

  function automatic logic complementary(input logic [BASE_W-1:0] a,
                                         input logic [BASE_W-1:0] b);
    logic res;
    begin
      case (a)
        BASE_A:  res = (b == BASE_T);
        BASE_C:  res = (b == BASE_G);
        BASE_G:  res = (b == BASE_C) || (b == BASE_T);
        BASE_T:  res = (b == BASE_A) || (b == BASE_G);
        default: res = 1'b0;
      endcase
      return res;
    end
  endfunction

endpackage

/* rtl/rnacla_ctrl.sv */
// Controller state machine: accepts words and sequences the row walk.
module rnacla_ctrl
  import rnacla_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    mode_i,
  input  status_t status_i,
  output logic    busy,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (!mode_i) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.row_start = 1'b1;
            if (!status_i.cnt_zero) begin
              state_d = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        busy           = 1'b1;
        cmd_o.col_step = 1'b1;
        if (status_i.last_col) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !status_i.cnt_zero)
    else $error("row walk running over an empty column list");
`endif

endmodule

/* rtl/rnacla_dp.sv */
// Datapath: settings, column and previous-row memories, cell scoring, result word.
module rnacla_dp
  import rnacla_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [BASE_W-1:0]   base_i,
  input  logic                restart_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic                valid_o,
  output logic [COL_W-1:0]    column_o,
  output logic [SCORE_W-1:0]  score_o,
  output logic [TRACE_W-1:0]  trace_o,
  output logic                last_o
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [7:0]         match_q;
  logic [8:0]         mismatch_q;
  logic [7:0]         gap_q;

  logic [BASE_W-1:0]  base_mem [MAX_COLS];
  logic [SCORE_W-1:0] prev_mem [MAX_COLS];

  logic [CNT_W-1:0]   cnt_q;
  logic               row_valid_q;
  logic               fresh_q;
  logic [BASE_W-1:0]  base_q;
  logic [AW-1:0]      col_q;
  logic [SCORE_W-1:0] diag_q;
  logic [SCORE_W-1:0] left_q;
  logic [BASE_W-1:0]  base_rd_q;
  logic [SCORE_W-1:0] prev_rd_q;

  logic               valid_q;
  logic [COL_W-1:0]   column_q;
  logic [SCORE_W-1:0] score_q;
  logic [TRACE_W-1:0] trace_q;
  logic               last_q;

  logic [CNT_W-1:0]   load_cnt;
  logic [AW-1:0]      rd_addr;
  logic [SCORE_W-1:0] above;
  logic signed [CAND_W-1:0] pair, cand_diag, cand_up, cand_left, best;
  logic [TRACE_W-1:0] trace_d;
  logic [SCORE_W-1:0] score_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= 8'd1;
      mismatch_q <= 9'h1FF;
      gap_q      <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MATCH:    match_q    <= cfg_data_i[7:0];
        REG_MISMATCH: mismatch_q <= cfg_data_i;
        REG_GAP:      gap_q      <= cfg_data_i[7:0];
        default:      ;
      endcase
    end
  end

  assign load_cnt = restart_i ? '0 : cnt_q;
  assign rd_addr  = cmd_i.row_start ? '0 : col_q + AW'(1);

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.last_col = ((CNT_W'(col_q) + CNT_W'(1)) == cnt_q);

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (load_cnt < CNT_W'(MAX_COLS))) begin
      base_mem[load_cnt[AW-1:0]] <= base_i;
    end
    if (cmd_i.col_step) begin
      prev_mem[col_q] <= score_d;
    end
    base_rd_q <= base_mem[rd_addr];
    prev_rd_q <= prev_mem[rd_addr];
  end

  // cell scoring
  always_comb begin
    above     = fresh_q ? '0 : prev_rd_q;
    pair      = complementary(base_q, base_rd_q) ? $signed({8'b0, match_q})
                                                 : $signed({{7{mismatch_q[8]}}, mismatch_q});
    cand_diag = $signed({2'b0, diag_q}) + pair;
    cand_up   = $signed({2'b0, above}) - $signed({8'b0, gap_q});
    cand_left = $signed({2'b0, left_q}) - $signed({8'b0, gap_q});
    best = '0;
    if (cand_diag > best) best = cand_diag;
    if (cand_up   > best) best = cand_up;
    if (cand_left > best) best = cand_left;
    trace_d = '0;
    if (best > 0) begin
      trace_d[0] = (cand_diag == best);
      trace_d[1] = (cand_up   == best);
      trace_d[2] = (cand_left == best);
    end
    score_d = (best > $signed({2'b0, SCORE_MAX})) ? SCORE_MAX : best[SCORE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      row_valid_q <= 1'b0;
      fresh_q     <= 1'b1;
      base_q      <= '0;
      col_q       <= '0;
      diag_q      <= '0;
      left_q      <= '0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= cmd_i.col_step;
      if (cmd_i.load) begin
        row_valid_q <= 1'b0;
        if (load_cnt < CNT_W'(MAX_COLS)) begin
          cnt_q <= load_cnt + CNT_W'(1);
        end else begin
          cnt_q <= load_cnt;
        end
      end
      if (cmd_i.row_start) begin
        base_q      <= base_i;
        fresh_q     <= restart_i || !row_valid_q;
        row_valid_q <= 1'b1;
        col_q       <= '0;
        diag_q      <= '0;
        left_q      <= '0;
      end
      if (cmd_i.col_step) begin
        col_q  <= col_q + AW'(1);
        diag_q <= above;
        left_q <= score_d;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_step) begin
      column_q <= COL_W'(col_q);
      score_q  <= score_d;
      trace_q  <= trace_d;
      last_q   <= status_o.last_col;
    end
  end

  assign valid_o  = valid_q;
  assign column_o = column_q;
  assign score_o  = score_q;
  assign trace_o  = trace_q;
  assign last_o   = last_q;

`ifndef NO_ASSERTIONS
  a_valid_from_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(cmd_i.col_step))
    else $error("result word without a scored cell");
  a_trace_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((score_q == '0) == (trace_q == '0)))
    else $error("trace and score disagree on a zero cell");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_COLS))
    else $error("column count beyond capacity");
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |=> !valid_q)
    else $error("result word right after the last column");
`endif

endmodule

/* rtl/rna_complement_local_alignment_row.sv */
// Top level of the RNA complement local alignment row engine.
// A word is taken when start is high and busy is low. A load word (mode 0) is
// absorbed in the cycle it is taken and busy stays low. A row word (mode 1) produces
// one result per loaded column, left to right, one per clock, marked by
// valid_o for a single cycle; the receiver must take each result as it comes.
// A row keeps busy high while its columns are being scored, and the
// next word can be taken in the cycle after the last column is scored, while
// that last result is on the outputs. The cell recurrence on the left
// neighbor through the shared scoring unit sets this one-column-per-cycle pace;
// column bases and the previous row sit in memories with one read and one
// write port, with a registered read one column ahead. A row over an empty column
// list returns nothing and leaves busy low.
module rna_complement_local_alignment_row
  import rnacla_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic [BASE_W-1:0]   base_i,
  input  logic                restart_i,
  output logic                valid_o,
  output logic [COL_W-1:0]    column_o,
  output logic [SCORE_W-1:0]  score_o,
  output logic [TRACE_W-1:0]  trace_o,
  output logic                last_o
);

  cmd_t    cmd;
  status_t status;

  rnacla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  rnacla_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .base_i     (base_i),
    .restart_i  (restart_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .valid_o    (valid_o),
    .column_o   (column_o),
    .score_o    (score_o),
    .trace_o    (trace_o),
    .last_o     (last_o)
  );

endmodule
